>>> design/nsc_pkg.sv
package nsc_pkg;

	// Characters that steer the sentence scan
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_NUL    = 8'h00;

	// Header letters and reset values of the header registers
	localparam int unsigned HDR_CHARS = 5;
	localparam int unsigned HDR_W     = 8 * HDR_CHARS;
	localparam logic [HDR_W-1:0] FIRST_HEADER_RST  = 40'h474E524D43; // "GNRMC"
	localparam logic [HDR_W-1:0] SECOND_HEADER_RST = 40'h474E474741; // "GNGGA"

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEADER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEADER = 2'd1;

	// Result status codes
	localparam logic [2:0] ST_TYPE_A   = 3'd0;
	localparam logic [2:0] ST_TYPE_B   = 3'd1;
	localparam logic [2:0] ST_OTHER    = 3'd2;
	localparam logic [2:0] ST_SUM_FAIL = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	localparam int unsigned LEN_W = 7;

	// Value of one hex character; anything else counts as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
		else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
		return v;
	endfunction

endpackage

>>> design/nmea_sentence_checker.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------------------
// input    | in_valid / in_ready   | rx_byte[7:0]
// output   | out_valid / out_ready | status[2:0], sentence_length[6:0],
//          |                       | computed_sum[7:0], received_sum[7:0]
// config   | cfg_write             | cfg_index[1:0], cfg_data[39:0]
//
// One byte per cycle unless the output stalls: a byte is held in the input register and its
// result, if any, is registered into the output register when that byte is scanned.
// The scan state update is a single XOR, count and compare step per byte.
// Reset clears the scan state and loads the default headers; no clearing pass.
// A result waiting in the output register stalls only when out_ready is low;
// the input register then holds its byte and in_ready drops.
module nmea_sentence_checker #(
	parameter int unsigned SENTENCE_BYTES = 128
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [7:0]                                rx_byte,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [2:0]                                status,
	output logic [nsc_pkg::LEN_W-1:0]                 sentence_length,
	output logic [7:0]                                computed_sum,
	output logic [7:0]                                received_sum,
	input  logic                                      cfg_write,
	input  logic [nsc_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [nsc_pkg::HDR_W-1:0]                 cfg_data
);
	import nsc_pkg::*;

	localparam int unsigned CNT_W = $clog2(SENTENCE_BYTES);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(SENTENCE_BYTES - 1);

	typedef enum logic [1:0] {
		PH_BODY,
		PH_SUM,
		PH_STOP,
		PH_DONE
	} phase_t;

	// Configuration registers
	logic [HDR_W-1:0] first_header_q;
	logic [HDR_W-1:0] second_header_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Scan state
	logic             in_sent_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       xor_q;
	phase_t           phase_q;
	logic [1:0]       digits_q;
	logic             zero_q;
	logic [7:0]       exp_q;
	logic [HDR_W-1:0] hdr_q;

	// Output register
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       csum_q;
	logic [7:0]       rsum_q;

	// Next state and result
	logic             in_sent_n;
	logic [CNT_W-1:0] cnt_n;
	logic [7:0]       xor_n;
	phase_t           phase_n;
	logic [1:0]       digits_n;
	logic             zero_n;
	logic [7:0]       exp_n;
	logic [HDR_W-1:0] hdr_n;
	logic             res_valid;
	logic [2:0]       res_status;
	logic [LEN_W-1:0] res_len;
	logic [7:0]       res_csum;
	logic [7:0]       res_rsum;
	logic             sum_ok;
	logic             advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Scan one byte against the sentence state
	always_comb begin
		in_sent_n  = in_sent_q;
		cnt_n      = cnt_q;
		xor_n      = xor_q;
		phase_n    = phase_q;
		digits_n   = digits_q;
		zero_n     = zero_q;
		exp_n      = exp_q;
		hdr_n      = hdr_q;
		res_valid  = 1'b0;
		res_status = ST_SUM_FAIL;
		res_len    = '0;
		res_csum   = 8'd0;
		res_rsum   = 8'd0;
		sum_ok     = 1'b0;
		if (byte_s1 == CHAR_DOLLAR) begin
			in_sent_n = 1'b1;
			cnt_n     = CNT_W'(1);
			xor_n     = 8'd0;
			phase_n   = PH_BODY;
			digits_n  = 2'd0;
			zero_n    = 1'b0;
			exp_n     = 8'd0;
			hdr_n     = '0;
		end else if (in_sent_q && cnt_q >= CNT_LIMIT) begin
			// drop an oversized sentence
			in_sent_n  = 1'b0;
			cnt_n      = '0;
			res_valid  = 1'b1;
			res_status = ST_OVERFLOW;
		end else if (in_sent_q) begin
			// capture header letters at positions one to five
			for (int unsigned i = 1; i <= HDR_CHARS; i++) begin
				if (cnt_q == CNT_W'(i))
					hdr_n[(HDR_CHARS-i)*8 +: 8] = hdr_q[(HDR_CHARS-i)*8 +: 8] | byte_s1;
			end
			cnt_n = cnt_q + CNT_W'(1);
			unique case (phase_q)
				PH_BODY: begin
					if (byte_s1 == CHAR_STAR) phase_n = PH_SUM;
					else if (byte_s1 == CHAR_NUL || byte_s1 == CHAR_CR ||
						byte_s1 == CHAR_LF) phase_n = PH_STOP;
					else xor_n = xor_q ^ byte_s1;
				end
				PH_SUM: begin
					if (byte_s1 == CHAR_NUL) zero_n = 1'b1;
					if (digits_q == 2'd0) begin
						exp_n    = {hex_value(byte_s1), 4'd0};
						digits_n = 2'd1;
					end else begin
						exp_n    = exp_q | {4'd0, hex_value(byte_s1)};
						digits_n = 2'd2;
						phase_n  = PH_DONE;
					end
				end
				PH_STOP, PH_DONE: ;
				default: ;
			endcase
			// report and close on line feed
			if (byte_s1 == CHAR_LF) begin
				sum_ok    = (phase_n == PH_DONE) && !zero_n && (xor_n == exp_n);
				res_valid = 1'b1;
				priority if (!sum_ok) res_status = ST_SUM_FAIL;
				else if (hdr_n == first_header_q) res_status = ST_TYPE_A;
				else if (hdr_n == second_header_q) res_status = ST_TYPE_B;
				else res_status = ST_OTHER;
				res_len   = LEN_W'(cnt_n);
				res_csum  = xor_n;
				res_rsum  = (phase_n == PH_SUM || phase_n == PH_DONE) ? exp_n : 8'd0;
				in_sent_n = 1'b0;
				cnt_n     = '0;
			end
		end
	end

	// Write header registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_header_q  <= FIRST_HEADER_RST;
			second_header_q <= SECOND_HEADER_RST;
		end else if (cfg_write) begin
			if (cfg_index == CFG_FIRST_HEADER) first_header_q <= cfg_data;
			if (cfg_index == CFG_SECOND_HEADER) second_header_q <= cfg_data;
		end
	end

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	// Advance the scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0;
			cnt_q     <= '0;
			xor_q     <= 8'd0;
			phase_q   <= PH_BODY;
			digits_q  <= 2'd0;
			zero_q    <= 1'b0;
			exp_q     <= 8'd0;
			hdr_q     <= '0;
		end else if (advance) begin
			in_sent_q <= in_sent_n;
			cnt_q     <= cnt_n;
			xor_q     <= xor_n;
			phase_q   <= phase_n;
			digits_q  <= digits_n;
			zero_q    <= zero_n;
			exp_q     <= exp_n;
			hdr_q     <= hdr_n;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			status_q <= res_status;
			len_q    <= res_len;
			csum_q   <= res_csum;
			rsum_q   <= res_rsum;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign sentence_length = len_q;
	assign computed_sum    = csum_q;
	assign received_sum    = rsum_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LIMIT)
		else $error("byte count beyond sentence limit");

	a_closed_count: assert property (@(posedge clk) disable iff (!arst_n)
		!in_sent_q |-> cnt_q == '0)
		else $error("closed sentence with nonzero count");

	a_phase_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) == (digits_q == 2'd2))
		else $error("sum phase and digit count disagree");

	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_OVERFLOW |->
			len_q == '0 && csum_q == 8'd0 && rsum_q == 8'd0)
		else $error("overflow result with nonzero fields");

	a_valid_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_TYPE_A || status_q == ST_TYPE_B ||
			status_q == ST_OTHER) |-> csum_q == rsum_q)
		else $error("valid sentence with unequal sums");

endmodule
